// ===== rtl/dsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_pkg
// Types and constants shared by the divisible subarray counter and its RAM.
// ----------------------------------------------------------------------------
package dsc_pkg;

	localparam int MAX_RESIDUES = 1024;
	localparam int MAX_ITEMS    = 65536;
	localparam int WAYS_MOD     = 20091101;

	localparam int RESIDUE_W = 10;
	localparam int DIVISOR_W = 11;
	localparam int WAYS_W    = 25;
	localparam int COUNT_W   = 17;
	localparam int STATUS_W  = 2;
	localparam int TAB_AW    = $clog2(MAX_RESIDUES);

	localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_RESIDUE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_TOO_LONG    = 2'd2;

	typedef struct packed {
		logic [RESIDUE_W-1:0] residue;
		logic                 last;
	} item_t;

	typedef struct packed {
		logic [WAYS_W-1:0]   ways_so_far;
		logic [COUNT_W-1:0]  max_disjoint_so_far;
		logic [STATUS_W-1:0] status;
		logic                last_out;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] best;
	} entry_t;

	typedef enum logic [0:0] {
		ST_CLEAR,
		ST_RUN
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/divisible_subarray_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// divisible_subarray_counter
// Counts subarrays with a sum divisible by the divisor from a stream of
// prefix-sum residues, and tracks the most non-overlapping such subarrays.
// ----------------------------------------------------------------------------
// Each input word on the item channel carries one prefix-sum residue and a
// last flag; the caller sends the leading zero residue itself. Every accepted
// word yields exactly one result word with the running subarray count modulo
// 20091101, the running disjoint maximum, a status code and the last flag.
// A result moves from the table stage into the output register. The block
// takes one item per cycle unless item_stall holds it, limited by the single
// read-modify-write of the residue table (1024 entries, one read and one write
// port, forwarding between back-to-back items on the same residue).
// After reset, and after each word marked last has left the table stage, the
// table is swept clear at one entry per cycle while item_stall stays high. The
// divisor write channel is always ready and may be written only while no item
// is in flight. When the receiver holds result_stall, the finished word waits
// in the output register, one more item can be taken into the table stage
// behind it, and item_stall rises until the output register drains.
// ----------------------------------------------------------------------------
module divisible_subarray_counter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire dsc_pkg::item_t                 item,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output dsc_pkg::result_t                    result,
	input  wire logic                           divisor_valid,
	output logic                                divisor_ready,
	input  wire logic [dsc_pkg::DIVISOR_W-1:0] divisor
);

	dsc_pkg::state_t state_q, state_d;
	logic [dsc_pkg::TAB_AW-1:0] clr_q;
	logic sweep, run_mode;

	logic [dsc_pkg::DIVISOR_W-1:0] divisor_q;
	logic [dsc_pkg::WAYS_W-1:0]    ways_q;
	logic [dsc_pkg::COUNT_W-1:0]   best_q;
	logic [dsc_pkg::COUNT_W-1:0]   items_q;

	logic                          valid_s1;
	logic [dsc_pkg::RESIDUE_W-1:0] residue_s1;
	logic                          last_s1;
	logic                          fwd_s1;
	dsc_pkg::entry_t               fwd_entry_s1;

	logic             out_valid_q;
	dsc_pkg::result_t result_q;

	logic accept, adv_s1, bad, too_long, ok;
	dsc_pkg::entry_t rd_entry, cur_entry, wr_entry;
	logic [$bits(dsc_pkg::entry_t)-1:0] ram_rdata, ram_wdata;
	logic ram_we, run_we;
	logic [dsc_pkg::TAB_AW-1:0] ram_waddr;
	logic [dsc_pkg::WAYS_W:0] ways_sum;
	logic [dsc_pkg::WAYS_W-1:0] ways_new, ways_upd;
	logic [dsc_pkg::COUNT_W-1:0] cand, best_upd;
	logic [dsc_pkg::STATUS_W-1:0] status;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dsc_pkg::ST_CLEAR: begin
				if (clr_q == dsc_pkg::TAB_AW'(dsc_pkg::MAX_RESIDUES - 1)) begin
					state_d = dsc_pkg::ST_RUN;
				end
			end
			dsc_pkg::ST_RUN: begin
				if (adv_s1 && last_s1) begin
					state_d = dsc_pkg::ST_CLEAR;
				end
			end
			default: state_d = dsc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		sweep    = 1'b0;
		run_mode = 1'b0;
		case (state_q)
			dsc_pkg::ST_CLEAR: sweep    = 1'b1;
			dsc_pkg::ST_RUN:   run_mode = 1'b1;
			default: begin
				sweep    = 1'b0;
				run_mode = 1'b0;
			end
		endcase
	end

	assign adv_s1     = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = !run_mode || (valid_s1 && (last_s1 || !adv_s1));
	assign accept     = item_valid && !item_stall;

	assign rd_entry  = ram_rdata;
	assign cur_entry = fwd_s1 ? fwd_entry_s1 : rd_entry;

	assign bad = ({1'b0, residue_s1} >= divisor_q) ||
		(32'(residue_s1) >= dsc_pkg::MAX_RESIDUES);
	assign too_long = 32'(items_q) >= dsc_pkg::MAX_ITEMS;
	assign ok = !bad && !too_long;

	always_comb begin
		ways_sum = {1'b0, ways_q} + (dsc_pkg::WAYS_W + 1)'(cur_entry.count);
		if (ways_sum >= (dsc_pkg::WAYS_W + 1)'(dsc_pkg::WAYS_MOD)) begin
			ways_new = dsc_pkg::WAYS_W'(ways_sum - (dsc_pkg::WAYS_W + 1)'(dsc_pkg::WAYS_MOD));
		end else begin
			ways_new = ways_sum[dsc_pkg::WAYS_W-1:0];
		end
		cand = cur_entry.best + dsc_pkg::COUNT_W'(1);
		if (cur_entry.count != '0 && cand > best_q) begin
			best_upd = ok ? cand : best_q;
		end else begin
			best_upd = best_q;
		end
		ways_upd = ok ? ways_new : ways_q;
		wr_entry.count = cur_entry.count + dsc_pkg::COUNT_W'(1);
		wr_entry.best  = best_upd;
		if (bad) begin
			status = dsc_pkg::STATUS_BAD_RESIDUE;
		end else if (too_long) begin
			status = dsc_pkg::STATUS_TOO_LONG;
		end else begin
			status = dsc_pkg::STATUS_OK;
		end
	end

	assign run_we    = adv_s1 && ok;
	assign ram_we    = sweep || run_we;
	assign ram_waddr = sweep ? clr_q : residue_s1[dsc_pkg::TAB_AW-1:0];
	assign ram_wdata = sweep ? '0 : wr_entry;

	dsc_ram #(
		.WIDTH($bits(dsc_pkg::entry_t)),
		.DEPTH(dsc_pkg::MAX_RESIDUES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(item.residue[dsc_pkg::TAB_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsc_pkg::ST_CLEAR;
			clr_q       <= '0;
			divisor_q   <= dsc_pkg::DIVISOR_W'(1);
			ways_q      <= '0;
			best_q      <= '0;
			items_q     <= '0;
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sweep) begin
				if (clr_q == dsc_pkg::TAB_AW'(dsc_pkg::MAX_RESIDUES - 1)) begin
					clr_q <= '0;
				end else begin
					clr_q <= clr_q + dsc_pkg::TAB_AW'(1);
				end
			end
			if (divisor_valid && divisor_ready) begin
				divisor_q <= divisor;
			end
			if (adv_s1) begin
				if (last_s1) begin
					ways_q  <= '0;
					best_q  <= '0;
					items_q <= '0;
				end else if (ok) begin
					ways_q  <= ways_upd;
					best_q  <= best_upd;
					items_q <= items_q + dsc_pkg::COUNT_W'(1);
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= run_we && (residue_s1 == item.residue);
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
				fwd_s1   <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			residue_s1   <= item.residue;
			last_s1      <= item.last;
			fwd_entry_s1 <= wr_entry;
		end
		if (adv_s1) begin
			result_q.ways_so_far         <= ways_upd;
			result_q.max_disjoint_so_far <= best_upd;
			result_q.status              <= status;
			result_q.last_out            <= last_s1;
		end
	end

	assign result_valid  = out_valid_q;
	assign result        = result_q;
	assign divisor_ready = 1'b1;

	a_ways_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ways_q) < dsc_pkg::WAYS_MOD)
		else $error("running subarray count reached the modulus");

	a_best_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= items_q)
		else $error("disjoint maximum exceeds the number of items taken");

	a_last_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> state_q == dsc_pkg::ST_CLEAR)
		else $error("closing word did not start the table sweep");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarded entry without an item in the pipeline");

	a_sweep_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsc_pkg::ST_CLEAR |-> !valid_s1)
		else $error("item in the pipeline during the table sweep");

endmodule
`default_nettype wire

// ===== rtl/dsc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire
